// ----- rtl/clnw_pkg.sv -----
// Shared types and constants of the character-LCD nibble writer.
package clnw_pkg;

	localparam int unsigned MAX_DIGITS_DEF  = 10;
	localparam int unsigned VALUE_WIDTH_DEF = 32;
	localparam int unsigned DIGIT_W         = 4;

	localparam logic [1:0] FUNC_CMD  = 2'd0;
	localparam logic [1:0] FUNC_DATA = 2'd1;
	localparam logic [1:0] FUNC_INT  = 2'd2;

	localparam logic [7:0] CHAR_MINUS   = 8'h2D;
	localparam logic [3:0] CHAR_ZERO_HI = 4'h3;

	typedef enum logic [1:0] {
		SRC_INPUT,
		SRC_MINUS,
		SRC_DIGIT
	} src_t;

	typedef struct packed {
		logic load;
		logic conv_step;
		logic dig_shift;
		logic push;
		src_t src;
		logic hi;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic conv_done;
		logic neg;
		logic emit_ok;
		logic dig_final;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/clnw_if.sv -----
// Valid/ready channel interfaces for requests and nibble writes.
interface clnw_req_if #(
	parameter int unsigned VALUE_WIDTH = clnw_pkg::VALUE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    func;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink (input valid, input func, input value, output ready);
endinterface

interface clnw_wr_if;
	logic       valid;
	logic       ready;
	logic [3:0] nibble;
	logic       reg_select;
	logic       last;

	modport source (output valid, output nibble, output reg_select, output last, input ready);
	modport sink (input valid, input nibble, input reg_select, input last, output ready);
endinterface

// ----- rtl/clnw_ctrl.sv -----
// Controller state machine: sequences conversion, digit scan and nibble writes.
module clnw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic [1:0]         req_func,
	output logic               req_ready,
	input  clnw_pkg::sts_t     sts,
	output clnw_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BYTE_HI,
		ST_BYTE_LO,
		ST_CONV,
		ST_SIGN_HI,
		ST_SIGN_LO,
		ST_SCAN,
		ST_DIG_HI,
		ST_DIG_LO
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.src       = clnw_pkg::SRC_INPUT;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					if (req_func inside {clnw_pkg::FUNC_CMD, clnw_pkg::FUNC_DATA}) begin
						state_d = ST_BYTE_HI;
					end else if (req_func == clnw_pkg::FUNC_INT) begin
						state_d = ST_CONV;
					end
				end
			end
			ST_BYTE_HI: begin
				cmd.src = clnw_pkg::SRC_INPUT;
				cmd.hi  = 1'b1;
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_BYTE_LO;
				end
			end
			ST_BYTE_LO: begin
				cmd.src  = clnw_pkg::SRC_INPUT;
				cmd.last = 1'b1;
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (sts.conv_done) begin
					state_d = sts.neg ? ST_SIGN_HI : ST_SCAN;
				end
			end
			ST_SIGN_HI: begin
				cmd.src = clnw_pkg::SRC_MINUS;
				cmd.hi  = 1'b1;
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_SIGN_LO;
				end
			end
			ST_SIGN_LO: begin
				cmd.src = clnw_pkg::SRC_MINUS;
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// drop leading zero digits
				if (sts.emit_ok) begin
					state_d = ST_DIG_HI;
				end else begin
					cmd.dig_shift = 1'b1;
				end
			end
			ST_DIG_HI: begin
				cmd.src = clnw_pkg::SRC_DIGIT;
				cmd.hi  = 1'b1;
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_DIG_LO;
				end
			end
			ST_DIG_LO: begin
				cmd.src  = clnw_pkg::SRC_DIGIT;
				cmd.last = sts.dig_final;
				if (sts.out_free) begin
					cmd.push      = 1'b1;
					cmd.dig_shift = 1'b1;
					state_d       = sts.dig_final ? ST_IDLE : ST_DIG_HI;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/clnw_dpath.sv -----
// Datapath: magnitude, shift-and-add-3 decimal conversion, digit store, output register.
module clnw_dpath #(
	parameter int unsigned MAX_DIGITS  = clnw_pkg::MAX_DIGITS_DEF,
	parameter int unsigned VALUE_WIDTH = clnw_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    req_func,
	input  logic signed [VALUE_WIDTH-1:0] req_value,
	input  clnw_pkg::cmd_t                cmd,
	output clnw_pkg::sts_t                sts,
	clnw_wr_if.source                     wr
);

	localparam int unsigned BIT_CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int unsigned DIG_CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int unsigned DW        = clnw_pkg::DIGIT_W;

	logic [VALUE_WIDTH-1:0] magnitude_q;
	logic                   neg_q;
	logic [7:0]             byte_q;
	logic                   byte_rs_q;
	logic [DW-1:0]          digit_store_q [MAX_DIGITS];
	logic [DW-1:0]          digit_adj [MAX_DIGITS];
	logic                   ovf_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [DIG_CNT_W-1:0]   dig_left_q;

	logic                   out_valid_q;
	logic [3:0]             nibble_q;
	logic                   rs_q;
	logic                   last_q;

	logic [VALUE_WIDTH-1:0] abs_value;
	logic [DW-1:0]          top_digit;
	logic [7:0]             sel_byte;
	logic                   sel_rs;

	assign abs_value = req_value[VALUE_WIDTH-1]
		? (~$unsigned(req_value)) + VALUE_WIDTH'(1)
		: $unsigned(req_value);

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			digit_adj[i] = (digit_store_q[i] >= DW'(5)) ? digit_store_q[i] + DW'(3)
			                                            : digit_store_q[i];
		end
	end

	assign top_digit = digit_store_q[MAX_DIGITS-1];

	assign sts.conv_done = (bit_cnt_q == BIT_CNT_W'(1));
	assign sts.neg       = neg_q;
	assign sts.emit_ok   = (top_digit != '0) || ovf_q || (dig_left_q == DIG_CNT_W'(1));
	assign sts.dig_final = (dig_left_q == DIG_CNT_W'(1));
	assign sts.out_free  = !out_valid_q || wr.ready;

	always_comb begin
		case (cmd.src)
			clnw_pkg::SRC_INPUT: begin
				sel_byte = byte_q;
				sel_rs   = byte_rs_q;
			end
			clnw_pkg::SRC_MINUS: begin
				sel_byte = clnw_pkg::CHAR_MINUS;
				sel_rs   = 1'b1;
			end
			clnw_pkg::SRC_DIGIT: begin
				sel_byte = {clnw_pkg::CHAR_ZERO_HI, top_digit};
				sel_rs   = 1'b1;
			end
			default: begin
				sel_byte = byte_q;
				sel_rs   = byte_rs_q;
			end
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q    <= req_value[7:0];
			byte_rs_q <= req_func[0];
			neg_q     <= req_value[VALUE_WIDTH-1];
		end
		if (cmd.push) begin
			nibble_q <= cmd.hi ? sel_byte[7:4] : sel_byte[3:0];
			rs_q     <= sel_rs;
			last_q   <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magnitude_q <= '0;
			ovf_q       <= 1'b0;
			bit_cnt_q   <= '0;
			dig_left_q  <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_DIGITS; i++) begin
				digit_store_q[i] <= '0;
			end
		end else begin
			if (cmd.load) begin
				magnitude_q <= abs_value;
				ovf_q       <= 1'b0;
				bit_cnt_q   <= BIT_CNT_W'(VALUE_WIDTH);
				dig_left_q  <= DIG_CNT_W'(MAX_DIGITS);
				for (int i = 0; i < MAX_DIGITS; i++) begin
					digit_store_q[i] <= '0;
				end
			end else if (cmd.conv_step) begin
				// shift one magnitude bit into the decimal digits; a carry out of
				// the top digit means more digits than are held
				magnitude_q <= magnitude_q << 1;
				bit_cnt_q   <= bit_cnt_q - BIT_CNT_W'(1);
				if (digit_adj[MAX_DIGITS-1][DW-1]) begin
					ovf_q <= 1'b1;
				end
				digit_store_q[0] <= {digit_adj[0][DW-2:0], magnitude_q[VALUE_WIDTH-1]};
				for (int i = 1; i < MAX_DIGITS; i++) begin
					digit_store_q[i] <= {digit_adj[i][DW-2:0], digit_adj[i-1][DW-1]};
				end
			end else if (cmd.dig_shift) begin
				// advance to the next lower digit
				dig_left_q       <= dig_left_q - DIG_CNT_W'(1);
				digit_store_q[0] <= '0;
				for (int i = 1; i < MAX_DIGITS; i++) begin
					digit_store_q[i] <= digit_store_q[i-1];
				end
			end

			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (wr.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign wr.valid      = out_valid_q;
	assign wr.nibble     = nibble_q;
	assign wr.reg_select = rs_q;
	assign wr.last       = last_q;

endmodule

// ----- rtl/char_lcd_nibble_writer_core.sv -----
// Top level of the character-LCD nibble writer.
//
// Requests arrive on req (func, value); nibble writes leave on wr (nibble,
// reg_select, last). A transaction moves at a clock edge where valid and ready
// are both high.
// func 0 and 1 send value[7:0] as two nibble writes, high nibble first, with
// reg_select 0 (command) or 1 (data). func 2 prints value as a signed decimal:
// an optional '-', then the digits most significant first, two nibble writes
// per character. func 3 is accepted and gives no writes.
// One request is handled at a time; req.ready is high only while idle.
// A byte request writes its high nibble, then its low nibble, and returns to
// idle. An integer request runs the shift-and-add-3 conversion, then drops
// leading zero digits until the leading digit is found, then writes each
// character as a high and a low nibble; it returns to idle once its last
// write has been pushed into the output register.
// Writes go out of a single output register; while wr.ready is low the
// write held there stays and the sequencer waits.
// Reset (arst_n low) empties the output register and returns to idle.
module char_lcd_nibble_writer_core #(
	parameter int unsigned MAX_DIGITS  = clnw_pkg::MAX_DIGITS_DEF,
	parameter int unsigned VALUE_WIDTH = clnw_pkg::VALUE_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	clnw_req_if.sink  req,
	clnw_wr_if.source wr
);

	clnw_pkg::cmd_t cmd;
	clnw_pkg::sts_t sts;

	clnw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	clnw_dpath #(
		.MAX_DIGITS  (MAX_DIGITS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_func  (req.func),
		.req_value (req.value),
		.cmd       (cmd),
		.sts       (sts),
		.wr        (wr)
	);

endmodule

// ----- bench/char_lcd_nibble_writer_core_tb.sv -----
// Self-checking bench for the character-LCD nibble writer: requests in, nibble writes out.
module char_lcd_nibble_writer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
	localparam int unsigned DIGITS       = clnw_pkg::MAX_DIGITS_DEF;
	localparam int unsigned RANDOM_ITEMS = 100;
	localparam int unsigned TAIL_START   = 80;
	localparam int unsigned DRAIN_AT     = 50;
	localparam int unsigned SETTLE       = clnw_pkg::VALUE_WIDTH_DEF + DIGITS + 40;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic [3:0] nibble;
		logic       reg_select;
		logic       last;
	} nibble_write_t;

	// typed rows carry the printed characters right-justified in text
	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] value;
		bit          typed;
		logic [87:0] text;
		int unsigned nchars;
	} request_row_t;

	logic clk = 1'b0;
	logic arst_n;

	clnw_req_if req_ch ();
	clnw_wr_if  wr_ch ();

	char_lcd_nibble_writer_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.wr     (wr_ch)
	);

	nibble_write_t pending_writes[$];
	nibble_write_t oldest_write;

	// own copy of the conversion state
	logic [3:0]  held_digits [DIGITS];
	int unsigned digit_total;

	int unsigned mismatches;
	int unsigned writes_checked;
	int unsigned int_requests;
	int unsigned cycle_count;
	int unsigned stall_left;
	int unsigned stall_pct;
	int unsigned send_gap_pct;

	request_row_t directed_rows [20];
	int unsigned  row_idx;
	int unsigned  char_idx;
	int unsigned  random_sent;
	int unsigned  pick;
	bit           drained_once;
	logic [1:0]   rnd_func;
	logic [31:0]  rnd_value;

	always #4 clk = ~clk;

	function automatic void queue_char(input logic [7:0] code, input logic rs, input logic fin);
		pending_writes.push_back('{nibble: code[7:4], reg_select: rs, last: 1'b0});
		pending_writes.push_back('{nibble: code[3:0], reg_select: rs, last: fin});
	endfunction

	function automatic void predict_request(input logic [1:0] f, input logic [31:0] v);
		logic        negative;
		logic [31:0] rest;
		int          k;
		case (f)
			clnw_pkg::FUNC_CMD, clnw_pkg::FUNC_DATA: begin
				queue_char(v[7:0], f[0], 1'b1);
			end
			clnw_pkg::FUNC_INT: begin
				negative = v[31];
				rest = negative ? (~v + 32'd1) : v;
				digit_total = 0;
				while (rest != 0 && digit_total < DIGITS) begin
					held_digits[digit_total] = 4'(rest % 10);
					rest = rest / 10;
					digit_total++;
				end
				if (negative)
					queue_char(clnw_pkg::CHAR_MINUS, 1'b1, 1'b0);
				if (digit_total == 0)
					queue_char({clnw_pkg::CHAR_ZERO_HI, 4'h0}, 1'b1, 1'b1);
				else
					for (k = int'(digit_total) - 1; k >= 0; k--)
						queue_char({clnw_pkg::CHAR_ZERO_HI, held_digits[k]}, 1'b1, k == 0);
			end
			default: ;
		endcase
	endfunction

	// hold the request until accepted; optional idle burst first
	task automatic offer_request(input logic [1:0] f, input logic [31:0] v);
		if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func  <= f;
		req_ch.value <= v;
		do @(posedge clk); while (!req_ch.ready);
		if (f == clnw_pkg::FUNC_INT)
			int_requests++;
	endtask

	function automatic logic [31:0] random_integer();
		logic [31:0] v;
		case ($urandom_range(0, 7))
			0: v = 32'h8000_0000;
			1: v = 32'h7FFF_FFFF;
			2: v = $urandom_range(0, 9);
			3: v = $urandom_range(0, 999);
			4: v = $urandom_range(0, 999999);
			5: v = $urandom_range(0, 999999999);
			default: v = $urandom;
		endcase
		if (v != 32'h8000_0000 && $urandom_range(0, 1) == 1)
			v = -v;
		return v;
	endfunction

	// receiver: random stall bursts
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
			stall_left = $urandom_range(1, 16);
		wr_ch.ready <= (stall_left == 0);
	end

	always @(posedge clk) begin
		if (arst_n && wr_ch.valid && wr_ch.ready) begin
			if (pending_writes.size() == 0) begin
				$error("unexpected nibble write: nibble %h reg_select %b last %b",
					wr_ch.nibble, wr_ch.reg_select, wr_ch.last);
				mismatches++;
			end else begin
				oldest_write = pending_writes.pop_front();
				writes_checked++;
				if (wr_ch.nibble !== oldest_write.nibble) begin
					$error("nibble: expected %h, got %h", oldest_write.nibble, wr_ch.nibble);
					mismatches++;
				end
				if (wr_ch.reg_select !== oldest_write.reg_select) begin
					$error("reg_select: expected %b, got %b",
						oldest_write.reg_select, wr_ch.reg_select);
					mismatches++;
				end
				if (wr_ch.last !== oldest_write.last) begin
					$error("last: expected %b, got %b", oldest_write.last, wr_ch.last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d writes outstanding",
				cycle_count, pending_writes.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func  = clnw_pkg::FUNC_CMD;
		req_ch.value = '0;
		stall_pct    = 10;
		send_gap_pct = 10;
		drained_once = 1'b0;

		directed_rows = '{
			'{clnw_pkg::FUNC_CMD,  32'h0000_0000,  1'b1, 88'h00,        1},
			'{clnw_pkg::FUNC_CMD,  32'hFFFF_FFFF,  1'b1, 88'hFF,        1},
			'{clnw_pkg::FUNC_DATA, 32'hAAAA_AA00,  1'b1, 88'h00,        1},
			'{clnw_pkg::FUNC_DATA, 32'h0000_00FF,  1'b1, 88'hFF,        1},
			'{clnw_pkg::FUNC_CMD,  32'h1234_565A,  1'b0, 88'h0,         0},
			'{clnw_pkg::FUNC_DATA, 32'h8000_00A5,  1'b0, 88'h0,         0},
			'{clnw_pkg::FUNC_INT,  32'd0,          1'b1, "0",           1},
			'{clnw_pkg::FUNC_INT,  32'd1,          1'b1, "1",           1},
			'{clnw_pkg::FUNC_INT,  32'hFFFF_FFFF,  1'b1, "-1",          2},
			'{clnw_pkg::FUNC_INT,  32'h7FFF_FFFF,  1'b1, "2147483647",  10},
			'{clnw_pkg::FUNC_INT,  32'h8000_0000,  1'b1, "-2147483648", 11},
			'{clnw_pkg::FUNC_INT,  32'd9,          1'b1, "9",           1},
			'{clnw_pkg::FUNC_INT,  32'd10,         1'b1, "10",          2},
			'{clnw_pkg::FUNC_INT,  -32'sd10,       1'b1, "-10",         3},
			'{clnw_pkg::FUNC_INT,  32'd1000000000, 1'b1, "1000000000",  10},
			'{clnw_pkg::FUNC_INT,  32'd999999999,  1'b0, 88'h0,         0},
			'{clnw_pkg::FUNC_INT,  32'hEDCB_A988,  1'b0, 88'h0,         0},
			'{FUNC_UNUSED,         32'hFFFF_FFFF,  1'b1, 88'h0,         0},
			'{FUNC_UNUSED,         32'h0000_0000,  1'b1, 88'h0,         0},
			'{clnw_pkg::FUNC_INT,  32'd123456789,  1'b0, 88'h0,         0}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row_idx = i;
			if (directed_rows[row_idx].typed) begin
				for (char_idx = 0; char_idx < directed_rows[row_idx].nchars; char_idx++)
					queue_char(directed_rows[row_idx].text[
							8 * (directed_rows[row_idx].nchars - 1 - char_idx) +: 8],
						directed_rows[row_idx].func != clnw_pkg::FUNC_CMD,
						char_idx == directed_rows[row_idx].nchars - 1);
			end else begin
				predict_request(directed_rows[row_idx].func, directed_rows[row_idx].value);
			end
			offer_request(directed_rows[row_idx].func, directed_rows[row_idx].value);
		end

		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if (random_sent >= TAIL_START) begin
				stall_pct    = 0;
				send_gap_pct = 0;
			end else if (random_sent % 20 == 0) begin
				pick         = $urandom_range(0, 2);
				stall_pct    = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
				pick         = $urandom_range(0, 2);
				send_gap_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
			end
			// drain once mid-run with the request channel quiet
			if (random_sent == DRAIN_AT && !drained_once) begin
				drained_once = 1'b1;
				req_ch.valid <= 1'b0;
				while (pending_writes.size() != 0) @(posedge clk);
			end

			pick = $urandom_range(0, 19);
			if (pick == 0)
				rnd_func = FUNC_UNUSED;
			else if (pick < 5)
				rnd_func = clnw_pkg::FUNC_CMD;
			else if (pick < 10)
				rnd_func = clnw_pkg::FUNC_DATA;
			else
				rnd_func = clnw_pkg::FUNC_INT;
			rnd_value = (rnd_func == clnw_pkg::FUNC_INT) ? random_integer() : $urandom;

			predict_request(rnd_func, rnd_value);
			offer_request(rnd_func, rnd_value);
			if (rnd_func != FUNC_UNUSED)
				random_sent++;
		end
		req_ch.valid <= 1'b0;

		while (pending_writes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d directed and %0d random requests (%0d integer prints);",
			$size(directed_rows), random_sent, int_requests);
		$display("checked %0d nibble writes under random stalls and request gaps.",
			writes_checked);
		if (mismatches == 0 && pending_writes.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/clnw_pkg.sv
rtl/clnw_if.sv
rtl/clnw_ctrl.sv
rtl/clnw_dpath.sv
rtl/char_lcd_nibble_writer_core.sv
bench/char_lcd_nibble_writer_core_tb.sv
